// ----- sv/ibcg_pkg.sv -----
// Shared constants, types and codes of the icon blitter.
// Used by every module of the block; depends on nothing.
package ibcg_pkg;

  localparam int SCREEN_W  = 240;
  localparam int SCREEN_H  = 160;
  localparam int ICON_SIZE = 32;

  // Icon position counters: column and row, each indexes 0 .. ICON_SIZE-1
  localparam int POS_W = (ICON_SIZE > 2) ? $clog2(ICON_SIZE) : 1;

  // Signed width for origin plus offset; covers 511 + 31 and -512
  localparam int COORD_W = 12;

  localparam int ORIGIN_W = 10;
  localparam int PIXEL_W  = 16;
  localparam int COLOR_W  = 15;
  localparam int CHAN_W   = 5;
  localparam int SCR_W    = 8;

  // Luma weights, sum scaled by 256
  localparam int LUMA_R = 77;
  localparam int LUMA_G = 150;
  localparam int LUMA_B = 29;
  localparam int LUMA_W = 13;
  // Dim factor 5/8
  localparam int DIM_MUL = 5;
  localparam int DIM_W   = 8;

  typedef enum logic [1:0] {
    MODE_COPY = 2'd0,
    MODE_GREY = 2'd1,
    MODE_HALF = 2'd2
  } mode_e;

  typedef struct packed {
    logic             we;
    logic [SCR_W-1:0] x;
    logic [SCR_W-1:0] y;
  } place_t;

endpackage

// ----- sv/ibcg_grey.sv -----
// Color path of the icon blitter: copy or dimmed integer-luma grey.
// Depends on ibcg_pkg.
module ibcg_grey (
  input  logic [ibcg_pkg::PIXEL_W-1:0] pixel_i,
  input  logic [1:0]                   mode_i,
  output logic [ibcg_pkg::COLOR_W-1:0] color_o
);

  logic [ibcg_pkg::CHAN_W-1:0] red;
  logic [ibcg_pkg::CHAN_W-1:0] green;
  logic [ibcg_pkg::CHAN_W-1:0] blue;
  logic [ibcg_pkg::LUMA_W-1:0] luma_sum;
  logic [ibcg_pkg::CHAN_W-1:0] luma;
  logic [ibcg_pkg::DIM_W-1:0]  dim_prod;
  logic [ibcg_pkg::CHAN_W-1:0] dim;

  assign red   = pixel_i[4:0];
  assign green = pixel_i[9:5];
  assign blue  = pixel_i[14:10];

  always_comb begin
    luma_sum = ibcg_pkg::LUMA_W'(red)   * ibcg_pkg::LUMA_W'(ibcg_pkg::LUMA_R)
             + ibcg_pkg::LUMA_W'(green) * ibcg_pkg::LUMA_W'(ibcg_pkg::LUMA_G)
             + ibcg_pkg::LUMA_W'(blue)  * ibcg_pkg::LUMA_W'(ibcg_pkg::LUMA_B);
    luma     = luma_sum[ibcg_pkg::LUMA_W-1:8];
    dim_prod = ibcg_pkg::DIM_W'(luma) * ibcg_pkg::DIM_W'(ibcg_pkg::DIM_MUL);
    dim      = dim_prod[ibcg_pkg::DIM_W-1:3];
  end

  always_comb begin
    unique case (mode_i)
      ibcg_pkg::MODE_GREY: color_o = {dim, dim, dim};
      default:             color_o = pixel_i[ibcg_pkg::COLOR_W-1:0];
    endcase
  end

endmodule

// ----- sv/ibcg_place.sv -----
// Target placement of one icon pixel: offset, half-size subsample and clip.
// Depends on ibcg_pkg.
module ibcg_place (
  input  logic                                opaque_i,
  input  logic signed [ibcg_pkg::ORIGIN_W-1:0] origin_x_i,
  input  logic signed [ibcg_pkg::ORIGIN_W-1:0] origin_y_i,
  input  logic [1:0]                          mode_i,
  input  logic [ibcg_pkg::POS_W-1:0]          col_i,
  input  logic [ibcg_pkg::POS_W-1:0]          row_i,
  output ibcg_pkg::place_t                    place_o
);

  logic [ibcg_pkg::POS_W-1:0]          col_eff;
  logic [ibcg_pkg::POS_W-1:0]          row_eff;
  logic                                mode_ok;
  logic signed [ibcg_pkg::COORD_W-1:0] tx;
  logic signed [ibcg_pkg::COORD_W-1:0] ty;
  logic                                on_screen;

  always_comb begin
    col_eff = col_i;
    row_eff = row_i;
    mode_ok = 1'b1;
    unique case (mode_i)
      ibcg_pkg::MODE_COPY,
      ibcg_pkg::MODE_GREY: mode_ok = 1'b1;
      ibcg_pkg::MODE_HALF: begin
        // drop odd rows and columns, halve the offsets
        mode_ok = ~col_i[0] & ~row_i[0];
        col_eff = col_i >> 1;
        row_eff = row_i >> 1;
      end
      default: mode_ok = 1'b0;
    endcase
  end

  always_comb begin
    tx = ibcg_pkg::COORD_W'(origin_x_i) + $signed(ibcg_pkg::COORD_W'(col_eff));
    ty = ibcg_pkg::COORD_W'(origin_y_i) + $signed(ibcg_pkg::COORD_W'(row_eff));
    on_screen = (tx >= 0) && (tx < $signed(ibcg_pkg::COORD_W'(ibcg_pkg::SCREEN_W)))
             && (ty >= 0) && (ty < $signed(ibcg_pkg::COORD_W'(ibcg_pkg::SCREEN_H)));
    place_o.we = opaque_i & mode_ok & on_screen;
    place_o.x  = place_o.we ? tx[ibcg_pkg::SCR_W-1:0] : '0;
    place_o.y  = place_o.we ? ty[ibcg_pkg::SCR_W-1:0] : '0;
  end

endmodule

// ----- sv/icon_blit_with_clip_and_grey.sv -----
// Icon blitter: RGB555 icon pixels, keyed by an opacity bit, to clipped screen writes.
// Each accepted input word passes the input register and then the result register to the output.
// Throughput: one word per cycle while the output is not stalled; the input register and the result register
// each hold one word, so input is taken while a finished result waits if the input register is empty.
// Reset: asynchronous, active low; clears valids and the icon position to (0, 0).
// Depends on ibcg_pkg, ibcg_place and ibcg_grey.
module icon_blit_with_clip_and_grey (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ibcg_pkg::PIXEL_W-1:0]        pixel_i,
  input  logic signed [ibcg_pkg::ORIGIN_W-1:0] origin_x_i,
  input  logic signed [ibcg_pkg::ORIGIN_W-1:0] origin_y_i,
  input  logic [1:0]                          mode_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                write_enable_o,
  output logic [ibcg_pkg::SCR_W-1:0]          screen_x_o,
  output logic [ibcg_pkg::SCR_W-1:0]          screen_y_o,
  output logic [ibcg_pkg::COLOR_W-1:0]        color_o,
  output logic                                icon_done_o
);

  localparam logic [ibcg_pkg::POS_W-1:0] PosLast = ibcg_pkg::POS_W'(ibcg_pkg::ICON_SIZE - 1);

  // Handshake control
  logic in_acc;
  logic s1_ready;
  logic out_ready;

  // Icon position counters, advance on every accepted word
  logic [ibcg_pkg::POS_W-1:0] col_q, col_d;
  logic [ibcg_pkg::POS_W-1:0] row_q, row_d;

  // Input register
  logic                                s1_valid_q, s1_valid_d;
  logic [ibcg_pkg::PIXEL_W-1:0]        pixel_q;
  logic signed [ibcg_pkg::ORIGIN_W-1:0] ox_q;
  logic signed [ibcg_pkg::ORIGIN_W-1:0] oy_q;
  logic [1:0]                          mode_q;
  logic [ibcg_pkg::POS_W-1:0]          s1_col_q;
  logic [ibcg_pkg::POS_W-1:0]          s1_row_q;

  // Combinational work between the registers
  ibcg_pkg::place_t             place;
  logic [ibcg_pkg::COLOR_W-1:0] color_raw;
  logic                         done_d;

  // Result register
  logic                         out_valid_q;
  logic                         we_q;
  logic [ibcg_pkg::SCR_W-1:0]   sx_q;
  logic [ibcg_pkg::SCR_W-1:0]   sy_q;
  logic [ibcg_pkg::COLOR_W-1:0] color_q;
  logic                         done_q;

  // The result register frees when empty or when its word leaves this cycle;
  // the input register frees when empty or when its word moves on.
  assign out_ready  = ~out_valid_q | ~out_stall_i;
  assign s1_ready   = ~s1_valid_q | out_ready;
  assign in_stall_o = ~s1_ready;
  assign in_acc     = in_valid_i & s1_ready;

  // Advance the column, wrap to the next row, wrap the icon after the last pixel
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (col_q == PosLast) begin
        col_d = '0;
        row_d = (row_q == PosLast) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_comb begin
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (out_ready) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Capture the input word with the position it belongs to
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pixel_q  <= pixel_i;
      ox_q     <= origin_x_i;
      oy_q     <= origin_y_i;
      mode_q   <= mode_i;
      s1_col_q <= col_q;
      s1_row_q <= row_q;
    end
  end

  ibcg_place u_place (
    .opaque_i   (pixel_q[ibcg_pkg::PIXEL_W-1]),
    .origin_x_i (ox_q),
    .origin_y_i (oy_q),
    .mode_i     (mode_q),
    .col_i      (s1_col_q),
    .row_i      (s1_row_q),
    .place_o    (place)
  );

  ibcg_grey u_grey (
    .pixel_i (pixel_q),
    .mode_i  (mode_q),
    .color_o (color_raw)
  );

  // Flag the last pixel of the icon whether or not it is plotted
  assign done_d = (s1_col_q == PosLast) && (s1_row_q == PosLast);

  // Load the result when it is free; hold it while stalled
  always_ff @(posedge clk_i) begin
    if (out_ready && s1_valid_q) begin
      we_q    <= place.we;
      sx_q    <= place.x;
      sy_q    <= place.y;
      color_q <= place.we ? color_raw : '0;
      done_q  <= done_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign write_enable_o = we_q;
  assign screen_x_o     = sx_q;
  assign screen_y_o     = sy_q;
  assign color_o        = color_q;
  assign icon_done_o    = done_q;

  // A plotted word always lands on the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_enable_o |->
      (32'(screen_x_o) < ibcg_pkg::SCREEN_W) && (32'(screen_y_o) < ibcg_pkg::SCREEN_H))
    else $error("plotted pixel outside the screen");

  // An unplotted word carries zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_enable_o |->
      (screen_x_o == '0) && (screen_y_o == '0) && (color_o == '0))
    else $error("unplotted pixel with nonzero fields");

  // The position wraps to the icon start after its last pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (col_q == PosLast) && (row_q == PosLast) |=> (col_q == '0) && (row_q == '0))
    else $error("icon position did not wrap");

  // Input stalls only when the input register holds a word that cannot move on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked word");

  // A word in the input register with room downstream reaches the output next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_ready |=> out_valid_o)
    else $error("word lost between input and result register");

endmodule
